// ===== rtl/core/mfpsc_pkg.sv =====
// Shared types and constants for the median-filtered puller speed regulator.
// No dependencies. Used by every file of the block.
`timescale 1ns / 1ps

package mfpsc_pkg;

  // field widths
  localparam int unsigned ACT_W    = 2;
  localparam int unsigned DIAM_W   = 12;
  localparam int unsigned SPEED_W  = 20;
  localparam int unsigned SETTLE_W = 16;
  localparam int unsigned AREA_W   = 24;
  localparam int unsigned GAIN_W   = 17;
  localparam int unsigned FLOW_W   = 44;

  // shared multiplier operand and product widths
  localparam int unsigned MUL_A_W = 44;
  localparam int unsigned MUL_B_W = 20;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_STARTING_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_AREA     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJUST_GAIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DIAMETER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE        = 3'd5;

  // register reset values
  localparam logic [AREA_W-1:0] RST_TARGET_AREA     = 24'd2405282;
  localparam logic [GAIN_W-1:0] RST_ADJUST_GAIN     = 17'd32768;
  localparam logic [DIAM_W-1:0] RST_TARGET_DIAMETER = 12'd1750;
  localparam logic [DIAM_W-1:0] RST_DEADZONE        = 12'd20;

  // pi in Q16 and speed ceiling
  localparam logic [MUL_B_W-1:0] PI_Q16    = 20'd205887;
  localparam logic [SPEED_W-1:0] SPEED_MAX = 20'hFFFFF;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_SET  = 2'd1,
    CMD_STOP = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MED,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_DIV,
    ST_MUL4,
    ST_UPD,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [DIAM_W-1:0] diameter_sample;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         drive_command;
    logic [SPEED_W-1:0] speed;
    logic [DIAM_W-1:0]  median_diameter;
    logic [FLOW_W-1:0]  flow_rate;
    logic [DIAM_W-1:0]  last_diameter;
    logic               regulating;
  } out_item_t;

endpackage

// ===== rtl/core/mfpsc_if.sv =====
// Valid/ready channel interfaces for input items and result items.
// Depends on mfpsc_pkg for the payload types.
`timescale 1ns / 1ps

interface mfpsc_in_if;
  logic                valid;
  logic                ready;
  mfpsc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mfpsc_out_if;
  logic                 valid;
  logic                 ready;
  mfpsc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mfpsc_median.sv =====
// Sample window memory and rank-selection median engine.
// Depends on mfpsc_pkg for widths.
`timescale 1ns / 1ps

module mfpsc_median #(
  parameter int unsigned WINDOW_SIZE = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             wr_en_i,
  input  logic [((WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1)-1:0] wr_addr_i,
  input  logic [mfpsc_pkg::DIAM_W-1:0]     wr_data_i,
  input  logic                             start_i,
  output logic                             done_o,
  output logic [mfpsc_pkg::DIAM_W-1:0]     median_o
);

  localparam int unsigned AW   = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned CW   = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned KW   = $clog2(WINDOW_SIZE + 3);
  localparam int unsigned R_LO = (WINDOW_SIZE - 1) / 2;
  localparam int unsigned R_HI = WINDOW_SIZE / 2;
  localparam int unsigned DW   = mfpsc_pkg::DIAM_W;

  logic [DW-1:0] win_q [WINDOW_SIZE];
  logic [DW-1:0] rdata_q;
  logic [AW-1:0] raddr;
  logic [KW-1:0] k_dec;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [AW-1:0] cand_idx_q, cand_idx_d;
  logic [KW-1:0] k_q, k_d;
  logic [DW-1:0] cand_q, cand_d;
  logic [CW-1:0] lt_q, lt_d;
  logic [CW-1:0] le_q, le_d;
  logic [DW-1:0] lo_q, lo_d;
  logic [DW-1:0] hi_q, hi_d;
  logic [DW:0]   mid_sum;

  // read address: candidate first, then every window entry
  assign k_dec = k_q - KW'(1);
  assign raddr = ((k_q == '0) || (k_q > KW'(WINDOW_SIZE))) ? cand_idx_q : k_dec[AW-1:0];

  // window memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      win_q[wr_addr_i] <= wr_data_i;
    end
    rdata_q <= win_q[raddr];
  end

  // sequencing of candidate passes and rank counts
  always_comb begin
    busy_d     = busy_q;
    done_d     = 1'b0;
    cand_idx_d = cand_idx_q;
    k_d        = k_q;
    cand_d     = cand_q;
    lt_d       = lt_q;
    le_d       = le_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    if (start_i && !busy_q) begin
      busy_d     = 1'b1;
      cand_idx_d = '0;
      k_d        = '0;
      lt_d       = '0;
      le_d       = '0;
    end else if (busy_q) begin
      k_d = k_q + KW'(1);
      if (k_q == KW'(1)) begin
        cand_d = rdata_q;
      end else if (k_q == KW'(WINDOW_SIZE + 2)) begin
        if ((lt_q <= CW'(R_LO)) && (CW'(R_LO) < le_q)) begin
          lo_d = cand_q;
        end
        if ((lt_q <= CW'(R_HI)) && (CW'(R_HI) < le_q)) begin
          hi_d = cand_q;
        end
        lt_d = '0;
        le_d = '0;
        k_d  = '0;
        if (cand_idx_q == AW'(WINDOW_SIZE - 1)) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          cand_idx_d = cand_idx_q + AW'(1);
        end
      end else if (k_q >= KW'(2)) begin
        if (rdata_q < cand_q) begin
          lt_d = lt_q + CW'(1);
        end
        if (rdata_q <= cand_q) begin
          le_d = le_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cand_idx_q <= cand_idx_d;
    cand_q     <= cand_d;
    lt_q       <= lt_d;
    le_q       <= le_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
  end

  // floor of the mean of the two middle values
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign median_o = mid_sum[DW:1];
  assign done_o   = done_q;

endmodule

// ===== rtl/core/mfpsc_div.sv =====
// Restoring divider, one quotient bit per cycle, for flow over target area.
// Depends on mfpsc_pkg for widths.
`timescale 1ns / 1ps

module mfpsc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [mfpsc_pkg::FLOW_W-1:0]  dividend_i,
  input  logic [mfpsc_pkg::AREA_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [mfpsc_pkg::FLOW_W-1:0]  quotient_o
);

  localparam int unsigned NW = mfpsc_pkg::FLOW_W;
  localparam int unsigned DW = mfpsc_pkg::AREA_W;
  localparam int unsigned CW = $clog2(NW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dvs_q, dvs_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  // shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[NW-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/core/median_filtered_puller_speed_control.sv =====
// Start, stop and non-adjusting ticks pass from the beat to ST_OUT, which loads the result
// register once it is free; an adjusting tick first runs ST_MED, ST_MUL1 to ST_MUL3, ST_DIV,
// ST_MUL4 and ST_UPD, with the median rank scan over the window memory and the 44-step divider.
// Throughput: one item at a time; a new beat is taken the cycle after the result is
// loaded.
// Reset is asynchronous and active low; window contents are not cleared, no clearing pass.
`timescale 1ns / 1ps

module median_filtered_puller_speed_control #(
  parameter int unsigned WINDOW_SIZE = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mfpsc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [mfpsc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  mfpsc_in_if.sink                              item_in,
  mfpsc_out_if.source                           result_out
);

  localparam int unsigned AW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned FW = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned SW = mfpsc_pkg::SPEED_W;
  localparam int unsigned DW = mfpsc_pkg::DIAM_W;
  localparam int unsigned LW = mfpsc_pkg::FLOW_W;
  localparam int unsigned AW_ = mfpsc_pkg::MUL_A_W;
  localparam int unsigned BW_ = mfpsc_pkg::MUL_B_W;
  localparam int unsigned PW_ = mfpsc_pkg::MUL_P_W;

  // configuration registers
  logic [SW-1:0]                   start_speed_q;
  logic [mfpsc_pkg::SETTLE_W-1:0]  settle_ticks_q;
  logic [mfpsc_pkg::AREA_W-1:0]    target_area_q;
  logic [mfpsc_pkg::GAIN_W-1:0]    gain_q;
  logic [DW-1:0]                   target_diam_q;
  logic [DW-1:0]                   deadzone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_speed_q  <= '0;
      settle_ticks_q <= '0;
      target_area_q  <= mfpsc_pkg::RST_TARGET_AREA;
      gain_q         <= mfpsc_pkg::RST_ADJUST_GAIN;
      target_diam_q  <= mfpsc_pkg::RST_TARGET_DIAMETER;
      deadzone_q     <= mfpsc_pkg::RST_DEADZONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mfpsc_pkg::CFG_STARTING_SPEED:  start_speed_q  <= cfg_data_i[SW-1:0];
        mfpsc_pkg::CFG_SETTLE_TICKS:    settle_ticks_q <= cfg_data_i[mfpsc_pkg::SETTLE_W-1:0];
        mfpsc_pkg::CFG_TARGET_AREA:     target_area_q  <= cfg_data_i[mfpsc_pkg::AREA_W-1:0];
        mfpsc_pkg::CFG_ADJUST_GAIN:     gain_q         <= cfg_data_i[mfpsc_pkg::GAIN_W-1:0];
        mfpsc_pkg::CFG_TARGET_DIAMETER: target_diam_q  <= cfg_data_i[DW-1:0];
        mfpsc_pkg::CFG_DEADZONE:        deadzone_q     <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  // regulator state
  mfpsc_pkg::state_e              state_q, state_d;
  mfpsc_pkg::cmd_e                cmd_q, cmd_d;
  logic [FW-1:0]                  fill_q, fill_d;
  logic [mfpsc_pkg::SETTLE_W-1:0] settle_q, settle_d;
  logic                           run_q, run_d;
  logic [SW-1:0]                  speed_q, speed_d;
  logic [DW-1:0]                  raw_q, raw_d;
  logic [DW-1:0]                  med_q, med_d;
  logic [LW-1:0]                  flow_q, flow_d;
  logic                           ovalid_q, ovalid_d;
  mfpsc_pkg::out_item_t           odata_q, odata_d;

  // datapath scratch registers
  logic [PW_-1:0] p_q, p_d;
  logic [LW-1:0]  diff_q, diff_d;
  logic           ge_q, ge_d;
  logic [LW:0]    corr_q, corr_d;

  // shared multiplier
  logic [AW_-1:0] mul_a;
  logic [BW_-1:0] mul_b;
  logic [PW_-1:0] prod;

  // submodule handshakes
  logic           med_start, med_done;
  logic [DW-1:0]  med_val;
  logic           win_we;
  logic           div_start, div_done;
  logic [LW-1:0]  div_quo;
  logic [mfpsc_pkg::AREA_W-1:0] divisor;

  logic           accept;
  logic           out_free;
  logic [LW+1:0]  sum_up;
  logic [DW-1:0]  diam_dev;

  assign accept   = item_in.valid && item_in.ready;
  assign out_free = !ovalid_q || result_out.ready;
  assign divisor  = (target_area_q == '0) ? mfpsc_pkg::AREA_W'(1) : target_area_q;

  mfpsc_median #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_median (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (win_we),
    .wr_addr_i (fill_q[AW-1:0]),
    .wr_data_i (item_in.data.diameter_sample),
    .start_i   (med_start),
    .done_o    (med_done),
    .median_o  (med_val)
  );

  mfpsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (flow_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // operand selection for the shared multiplier
  always_comb begin
    case (state_q)
      mfpsc_pkg::ST_MUL1: begin
        mul_a = AW_'(med_q);
        mul_b = BW_'(med_q);
      end
      mfpsc_pkg::ST_MUL2: begin
        mul_a = AW_'(p_q[2*DW-1:0]);
        mul_b = BW_'(speed_q);
      end
      mfpsc_pkg::ST_MUL3: begin
        mul_a = p_q[AW_-1:0];
        mul_b = mfpsc_pkg::PI_Q16;
      end
      mfpsc_pkg::ST_MUL4: begin
        mul_a = diff_q;
        mul_b = BW_'(gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign sum_up   = (LW+2)'(speed_q) + (LW+2)'(corr_q);
  assign diam_dev = (med_q >= target_diam_q) ? (med_q - target_diam_q)
                                             : (target_diam_q - med_q);

  // sequencer: next state and register updates
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    fill_d    = fill_q;
    settle_d  = settle_q;
    run_d     = run_q;
    speed_d   = speed_q;
    raw_d     = raw_q;
    med_d     = med_q;
    flow_d    = flow_q;
    ovalid_d  = ovalid_q;
    odata_d   = odata_q;
    p_d       = p_q;
    diff_d    = diff_q;
    ge_d      = ge_q;
    corr_d    = corr_q;
    med_start = 1'b0;
    div_start = 1'b0;
    win_we    = 1'b0;

    // result register drains independently
    if (ovalid_q && result_out.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      mfpsc_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_d   = mfpsc_pkg::CMD_NONE;
          state_d = mfpsc_pkg::ST_OUT;
          case (mfpsc_pkg::action_e'(item_in.data.action))
            mfpsc_pkg::ACT_START: begin
              speed_d  = start_speed_q;
              raw_d    = item_in.data.diameter_sample;
              settle_d = settle_ticks_q;
              run_d    = 1'b1;
              cmd_d    = mfpsc_pkg::CMD_SET;
            end
            mfpsc_pkg::ACT_STOP: begin
              run_d    = 1'b0;
              speed_d  = '0;
              settle_d = '0;
              cmd_d    = mfpsc_pkg::CMD_STOP;
            end
            mfpsc_pkg::ACT_TICK: begin
              if (run_q) begin
                raw_d = item_in.data.diameter_sample;
                if (settle_q != '0) begin
                  settle_d = settle_q - mfpsc_pkg::SETTLE_W'(1);
                end else if (fill_q < FW'(WINDOW_SIZE)) begin
                  win_we = 1'b1;
                  fill_d = fill_q + FW'(1);
                end else begin
                  med_start = 1'b1;
                  state_d   = mfpsc_pkg::ST_MED;
                end
              end
            end
            default: ;
          endcase
        end
      end
      mfpsc_pkg::ST_MED: begin
        if (med_done) begin
          med_d   = med_val;
          state_d = mfpsc_pkg::ST_MUL1;
        end
      end
      mfpsc_pkg::ST_MUL1: begin
        p_d     = prod;
        state_d = mfpsc_pkg::ST_MUL2;
      end
      mfpsc_pkg::ST_MUL2: begin
        p_d     = prod;
        state_d = mfpsc_pkg::ST_MUL3;
      end
      mfpsc_pkg::ST_MUL3: begin
        // drop the Q16 of pi and the quarter from (d/2)^2
        flow_d  = prod[LW+17:18];
        state_d = mfpsc_pkg::ST_DIV;
      end
      mfpsc_pkg::ST_DIV: begin
        div_start = 1'b1;
        if (div_done) begin
          div_start = 1'b0;
          ge_d      = div_quo >= LW'(speed_q);
          diff_d    = (div_quo >= LW'(speed_q)) ? (div_quo - LW'(speed_q))
                                                : (LW'(speed_q) - div_quo);
          state_d   = mfpsc_pkg::ST_MUL4;
        end
      end
      mfpsc_pkg::ST_MUL4: begin
        corr_d  = prod[LW+16:16];
        state_d = mfpsc_pkg::ST_UPD;
      end
      mfpsc_pkg::ST_UPD: begin
        fill_d   = '0;
        settle_d = settle_ticks_q;
        cmd_d    = mfpsc_pkg::CMD_NONE;
        if (diam_dev > deadzone_q) begin
          cmd_d = mfpsc_pkg::CMD_SET;
          if (ge_q) begin
            speed_d = (sum_up > (LW+2)'(mfpsc_pkg::SPEED_MAX)) ? mfpsc_pkg::SPEED_MAX
                                                               : sum_up[SW-1:0];
          end else begin
            speed_d = (corr_q >= (LW+1)'(speed_q)) ? '0 : (speed_q - corr_q[SW-1:0]);
          end
        end
        state_d = mfpsc_pkg::ST_OUT;
      end
      mfpsc_pkg::ST_OUT: begin
        if (out_free) begin
          ovalid_d                = 1'b1;
          odata_d.drive_command   = cmd_q;
          odata_d.speed           = speed_q;
          odata_d.median_diameter = med_q;
          odata_d.flow_rate       = flow_q;
          odata_d.last_diameter   = raw_q;
          odata_d.regulating      = run_q;
          state_d                 = mfpsc_pkg::ST_IDLE;
        end
      end
      default: state_d = mfpsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mfpsc_pkg::ST_IDLE;
      cmd_q    <= mfpsc_pkg::CMD_NONE;
      fill_q   <= '0;
      settle_q <= '0;
      run_q    <= 1'b0;
      speed_q  <= '0;
      raw_q    <= '0;
      med_q    <= '0;
      flow_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      fill_q   <= fill_d;
      settle_q <= settle_d;
      run_q    <= run_d;
      speed_q  <= speed_d;
      raw_q    <= raw_d;
      med_q    <= med_d;
      flow_q   <= flow_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    p_q     <= p_d;
    diff_q  <= diff_d;
    ge_q    <= ge_d;
    corr_q  <= corr_d;
  end

  // channel ports
  assign item_in.ready    = (state_q == mfpsc_pkg::ST_IDLE);
  assign result_out.valid = ovalid_q;
  assign result_out.data  = odata_q;

endmodule

// ===== rtl/core/mfpsc_checker.sv =====
// Port-level checks for the puller speed regulator, bound to the top level.
// Depends on mfpsc_pkg for payload types and command codes.
`timescale 1ns / 1ps

module mfpsc_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input mfpsc_pkg::out_item_t out_data_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_data_i)))
    else $error("result beat changed while stalled");

  // one item at a time: ready drops after a beat is taken
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("input taken while an item is in flight");

  // a stop result shows the regulator halted
  a_stop_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_data_i.drive_command == mfpsc_pkg::CMD_STOP)) |->
    (!out_data_i.regulating && (out_data_i.speed == '0)))
    else $error("stop result with running state");

  // a set-speed result only comes while running
  a_set_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_data_i.drive_command == mfpsc_pkg::CMD_SET)) |->
    out_data_i.regulating)
    else $error("set speed while stopped");

endmodule

bind median_filtered_puller_speed_control mfpsc_checker u_mfpsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_in.valid),
  .in_ready_i  (item_in.ready),
  .out_valid_i (result_out.valid),
  .out_ready_i (result_out.ready),
  .out_data_i  (result_out.data)
);

// ===== tb/sv/tb_median_filtered_puller_speed_control.sv =====
// Self-checking bench for the median-filtered puller speed regulator.
// Depends on mfpsc_pkg, the mfpsc_in_if/mfpsc_out_if channels and the block's top level.
`timescale 1ns / 1ps

module tb_median_filtered_puller_speed_control;

  localparam int unsigned WIN        = 8;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned DW         = mfpsc_pkg::DIAM_W;
  localparam int unsigned CDW        = mfpsc_pkg::CFG_DATA_W;
  localparam logic [mfpsc_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  // speed regulator model plus queue of expected result beats
  class speed_scoreboard;
    logic [DW-1:0]                     window[WIN];
    int unsigned                       fill;
    logic [mfpsc_pkg::SETTLE_W-1:0]    settle_left;
    bit                                running;
    logic [mfpsc_pkg::SPEED_W-1:0]     speed_now;
    logic [DW-1:0]                     raw_d, median_now;
    logic [mfpsc_pkg::FLOW_W-1:0]      flow_now;
    logic [mfpsc_pkg::SPEED_W-1:0]     start_speed;
    logic [mfpsc_pkg::SETTLE_W-1:0]    settle_cfg;
    logic [mfpsc_pkg::AREA_W-1:0]      area_cfg;
    logic [mfpsc_pkg::GAIN_W-1:0]      gain_cfg;
    logic [DW-1:0]                     target_d, dead_cfg;
    mfpsc_pkg::out_item_t              expected_q[$];
    int unsigned                       errors;

    function void clear();
      fill = 0; settle_left = 0; running = 0; speed_now = 0;
      raw_d = 0; median_now = 0; flow_now = 0;
      start_speed = 0; settle_cfg = 0; area_cfg = mfpsc_pkg::RST_TARGET_AREA;
      gain_cfg = mfpsc_pkg::RST_ADJUST_GAIN; target_d = mfpsc_pkg::RST_TARGET_DIAMETER;
      dead_cfg = mfpsc_pkg::RST_DEADZONE; errors = 0;
    endfunction

    function void write_reg(logic [mfpsc_pkg::CFG_IDX_W-1:0] idx, logic [CDW-1:0] val);
      case (idx)
        mfpsc_pkg::CFG_STARTING_SPEED:  start_speed = val[mfpsc_pkg::SPEED_W-1:0];
        mfpsc_pkg::CFG_SETTLE_TICKS:    settle_cfg = val[mfpsc_pkg::SETTLE_W-1:0];
        mfpsc_pkg::CFG_TARGET_AREA:     area_cfg = val[mfpsc_pkg::AREA_W-1:0];
        mfpsc_pkg::CFG_ADJUST_GAIN:     gain_cfg = val[mfpsc_pkg::GAIN_W-1:0];
        mfpsc_pkg::CFG_TARGET_DIAMETER: target_d = val[DW-1:0];
        mfpsc_pkg::CFG_DEADZONE:        dead_cfg = val[DW-1:0];
        default: ;
      endcase
    endfunction

    // median, flow, ideal speed and proportional move; returns the drive command
    function mfpsc_pkg::cmd_e regulate();
      logic [DW-1:0] s[WIN];
      logic [DW-1:0] tmp;
      bit [63:0] m, v, flow, ideal, corr, nxt, area, dev;
      s = window;
      for (int i = 0; i < WIN; i++)
        for (int j = 0; j < WIN - 1 - i; j++)
          if (s[j] > s[j+1]) begin
            tmp = s[j]; s[j] = s[j+1]; s[j+1] = tmp;
          end
      if (WIN % 2 != 0) m = s[WIN/2];
      else m = (64'(s[(WIN-1)/2]) + 64'(s[WIN/2])) >> 1;
      median_now = m[DW-1:0];
      v = speed_now;
      flow = (v * m * m * 64'(mfpsc_pkg::PI_Q16)) >> 18;
      flow_now = flow[mfpsc_pkg::FLOW_W-1:0];
      area = (area_cfg == 0) ? 64'd1 : 64'(area_cfg);
      ideal = flow / area;
      if (ideal >= v) begin
        corr = ((ideal - v) * 64'(gain_cfg)) >> 16;
        nxt = v + corr;
        if (nxt > 64'(mfpsc_pkg::SPEED_MAX)) nxt = 64'(mfpsc_pkg::SPEED_MAX);
      end else begin
        corr = ((v - ideal) * 64'(gain_cfg)) >> 16;
        nxt = (corr >= v) ? 64'd0 : v - corr;
      end
      fill = 0;
      settle_left = settle_cfg;
      dev = (m >= target_d) ? m - target_d : 64'(target_d) - m;
      if (dev > 64'(dead_cfg)) begin
        speed_now = nxt[mfpsc_pkg::SPEED_W-1:0];
        return mfpsc_pkg::CMD_SET;
      end
      return mfpsc_pkg::CMD_NONE;
    endfunction

    function void note_input(mfpsc_pkg::in_item_t it);
      mfpsc_pkg::out_item_t r;
      mfpsc_pkg::cmd_e cmd;
      cmd = mfpsc_pkg::CMD_NONE;
      if (it.action == mfpsc_pkg::ACT_START) begin
        speed_now = start_speed; raw_d = it.diameter_sample;
        settle_left = settle_cfg; running = 1; cmd = mfpsc_pkg::CMD_SET;
      end else if (it.action == mfpsc_pkg::ACT_STOP) begin
        running = 0; speed_now = 0; settle_left = 0; cmd = mfpsc_pkg::CMD_STOP;
      end else if (it.action == mfpsc_pkg::ACT_TICK && running) begin
        raw_d = it.diameter_sample;
        if (settle_left != 0) settle_left--;
        else if (fill < WIN) begin
          window[fill] = it.diameter_sample;
          fill++;
        end else cmd = regulate();
      end
      r.drive_command = cmd; r.speed = speed_now; r.median_diameter = median_now;
      r.flow_rate = flow_now; r.last_diameter = raw_d; r.regulating = running;
      expected_q.push_back(r);
    endfunction

    function void check_result(mfpsc_pkg::out_item_t got);
      mfpsc_pkg::out_item_t e;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.drive_command !== e.drive_command) begin
        $error("drive_command exp %0d got %0d", e.drive_command, got.drive_command); errors++;
      end
      if (got.speed !== e.speed) begin
        $error("speed exp %0d got %0d", e.speed, got.speed); errors++;
      end
      if (got.median_diameter !== e.median_diameter) begin
        $error("median_diameter exp %0d got %0d", e.median_diameter, got.median_diameter);
        errors++;
      end
      if (got.flow_rate !== e.flow_rate) begin
        $error("flow_rate exp %0d got %0d", e.flow_rate, got.flow_rate); errors++;
      end
      if (got.last_diameter !== e.last_diameter) begin
        $error("last_diameter exp %0d got %0d", e.last_diameter, got.last_diameter); errors++;
      end
      if (got.regulating !== e.regulating) begin
        $error("regulating exp %0d got %0d", e.regulating, got.regulating); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [mfpsc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CDW-1:0]                  cfg_data_i = '0;
  bit send_idle = 1, recv_idle = 1;
  int unsigned quiet_cycles = 0;
  speed_scoreboard sb;

  mfpsc_in_if  in_ch ();
  mfpsc_out_if out_ch ();

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  median_filtered_puller_speed_control #(.WINDOW_SIZE(WIN)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .item_in(in_ch), .result_out(out_ch)
  );

  always #5 clk_i = ~clk_i;

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side with random stalls
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = recv_idle ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        out_ch.ready <= 0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1;
      do @(posedge clk_i); while (!out_ch.valid);
      sb.check_result(out_ch.data);
    end
  end

  task automatic send_item(logic [mfpsc_pkg::ACT_W-1:0] act, logic [DW-1:0] d);
    mfpsc_pkg::in_item_t it;
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    it.action = act;
    it.diameter_sample = d;
    in_ch.data <= it;
    in_ch.valid <= 1;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // write enable stays high across back-to-back writes; load_regs drops it
  task automatic write_reg(logic [mfpsc_pkg::CFG_IDX_W-1:0] idx, logic [CDW-1:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic load_regs(int unsigned ss, int unsigned st, int unsigned ar,
                           int unsigned gn, int unsigned td, int unsigned dz);
    write_reg(mfpsc_pkg::CFG_STARTING_SPEED, CDW'(ss));
    write_reg(mfpsc_pkg::CFG_SETTLE_TICKS, CDW'(st));
    write_reg(mfpsc_pkg::CFG_TARGET_AREA, CDW'(ar));
    write_reg(mfpsc_pkg::CFG_ADJUST_GAIN, CDW'(gn));
    write_reg(mfpsc_pkg::CFG_TARGET_DIAMETER, CDW'(td));
    write_reg(mfpsc_pkg::CFG_DEADZONE, CDW'(dz));
    cfg_we_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [DW-1:0] pick_diameter(int unsigned target);
    int d;
    if ($urandom_range(0, 1) == 0) return DW'($urandom_range(0, 4095));
    d = int'(target) + int'($urandom_range(0, 400)) - 200;
    if (d < 0) d = 0;
    if (d > 4095) d = 4095;
    return DW'(d);
  endfunction

  initial begin
    int unsigned r, n_items;
    sb = new();
    sb.clear();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, every action, stopped tick, unused code, restart, both deadzone cases
    load_regs(1000, 0, mfpsc_pkg::RST_TARGET_AREA, mfpsc_pkg::RST_ADJUST_GAIN,
              mfpsc_pkg::RST_TARGET_DIAMETER, mfpsc_pkg::RST_DEADZONE);
    send_item(mfpsc_pkg::ACT_TICK, 12'd4095);
    send_item(ACT_UNUSED, 12'd123);
    send_item(mfpsc_pkg::ACT_START, 12'd0);
    send_item(mfpsc_pkg::ACT_START, 12'd4095);
    for (int i = 0; i < WIN; i++) send_item(mfpsc_pkg::ACT_TICK, 12'd1750);
    send_item(mfpsc_pkg::ACT_TICK, 12'd1750);
    for (int i = 0; i < WIN; i++) send_item(mfpsc_pkg::ACT_TICK, (i % 2) ? 12'd4095 : 12'd0);
    send_item(mfpsc_pkg::ACT_TICK, 12'd2000);
    send_item(mfpsc_pkg::ACT_STOP, 12'd555);
    send_item(mfpsc_pkg::ACT_TICK, 12'd100);
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 7; ph++) begin
      send_idle = (ph % 3) != 1;
      recv_idle = (ph % 3) != 2;
      case (ph)
        0: load_regs($urandom_range(0, 1048575), 0, mfpsc_pkg::RST_TARGET_AREA, 32768, 1750, 20);
        1: load_regs(1048575, 3, 16777215, 131071, 4095, 0);
        2: load_regs(1, 0, 0, 0, 0, 4095);
        3: load_regs($urandom_range(0, 1048575), 1, 1, 65536, 1750, 0);
        4: load_regs(0, 65535, 1, 65536, 2000, 10);
        5: load_regs($urandom_range(0, 1048575), $urandom_range(0, 2),
                     $urandom_range(0, 16777215), $urandom_range(0, 131071),
                     $urandom_range(0, 4095), $urandom_range(0, 300));
        default: load_regs($urandom_range(1000, 400000), 0, $urandom_range(1, 4000000),
                           $urandom_range(0, 65536), 1750, $urandom_range(0, 50));
      endcase
      n_items = (ph == 4) ? 20 : 95;
      send_item(mfpsc_pkg::ACT_START, pick_diameter(sb.target_d));
      for (int i = 0; i < n_items; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) send_item(mfpsc_pkg::ACT_START, pick_diameter(sb.target_d));
        else if (r < 5) send_item(mfpsc_pkg::ACT_STOP, DW'($urandom_range(0, 4095)));
        else if (r < 7) send_item(ACT_UNUSED, DW'($urandom_range(0, 4095)));
        else send_item(mfpsc_pkg::ACT_TICK, pick_diameter(sb.target_d));
        // hold off once until every expected beat has come back
        if (ph == 0 && i == 40) drain();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
